// ----- rtl/core/sse_pkg.sv -----
// shared types and constants for the sorted set engine
// request/response payload structs, status codes, controller-datapath command types
package sse_pkg;

  localparam int DEFAULT_CAPACITY = 256;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [2:0] ST_INSERTED   = 3'd0;
  localparam logic [2:0] ST_DUPLICATE  = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_REMOVED    = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_FOUND      = 3'd5;
  localparam logic [2:0] ST_ABSENT     = 3'd6;
  localparam logic [2:0] ST_READ_RANGE = 3'd7;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic [7:0]         slot;
  } sse_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         position;
    logic [8:0]         entry_count;
    logic signed [31:0] read_value;
  } sse_rsp_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SRCH_RD,
    DP_SRCH_UPD,
    DP_PROBE_RD,
    DP_INIT_INS,
    DP_INIT_REM,
    DP_INS_RD,
    DP_INS_WR,
    DP_REM_RD,
    DP_REM_WR,
    DP_FINISH
  } dp_op_t;

  typedef enum logic [1:0] {
    POS_NONE,
    POS_IDX,
    POS_SLOT
  } pos_src_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] status;
    pos_src_t   pos_src;
    logic       rv_en;
    logic       wr_key;
    logic       cnt_inc;
    logic       cnt_dec;
  } sse_cmd_t;

  typedef struct packed {
    logic srch_open;
    logic less;
    logic hit;
    logic full;
    logic ins_more;
    logic rem_more;
    logic slot_ok;
  } sse_sts_t;

endpackage

// ----- rtl/core/sse_datapath.sv -----
// datapath: sorted entry memory, search bounds, shift pointer, count and result register
// depends on sse_pkg
module sse_datapath #(
  parameter int CAPACITY = sse_pkg::DEFAULT_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sse_pkg::sse_req_t req,
  input  sse_pkg::sse_cmd_t cmd,
  output sse_pkg::sse_sts_t sts,
  output logic              out_valid,
  output sse_pkg::sse_rsp_t out_rsp
);
  import sse_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 9) ? CW : 9;

  logic [31:0]        mem [CAPACITY];
  logic [31:0]        rd_q;
  logic signed [31:0] key_r;
  logic [7:0]         slot_r;
  logic [CW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, ptr_r, ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW:0]        mid_sum;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic [31:0]        wr_data;
  logic [XW-1:0]      slot_x, count_x, lo_x, cnt_nxt_x;
  logic               out_valid_nxt;
  sse_rsp_t           rsp_nxt;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign slot_x    = XW'(slot_r);
  assign count_x   = XW'(count_r);
  assign lo_x      = XW'(lo_r);
  assign cnt_nxt_x = XW'(count_nxt);

  assign sts.srch_open = lo_r < hi_r;
  assign sts.less      = $signed(rd_q) < key_r;
  assign sts.hit       = (lo_r < count_r) && (rd_q == key_r);
  assign sts.full      = count_r >= CW'(CAPACITY);
  assign sts.ins_more  = ptr_r > lo_r;
  assign sts.rem_more  = (ptr_r + CW'(1)) < count_r;
  assign sts.slot_ok   = slot_x < count_x;

  always_comb begin
    rd_addr = lo_r[AW-1:0];
    unique case (cmd.op)
      DP_LOAD:    rd_addr = AW'(XW'(req.slot));
      DP_SRCH_RD: rd_addr = mid_sum[AW:1];
      DP_INS_RD:  rd_addr = AW'(ptr_r - CW'(1));
      DP_REM_RD:  rd_addr = AW'(ptr_r + CW'(1));
      default:    rd_addr = lo_r[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[AW-1:0];
    wr_data = rd_q;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    ptr_nxt   = ptr_r;
    count_nxt = count_r;
    unique case (cmd.op)
      DP_LOAD: begin
        lo_nxt = '0;
        hi_nxt = count_r;
      end
      DP_SRCH_RD:  mid_nxt = mid_sum[CW:1];
      DP_SRCH_UPD: begin
        if (sts.less) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
      end
      DP_INIT_INS: ptr_nxt = count_r;
      DP_INIT_REM: ptr_nxt = lo_r;
      DP_INS_WR: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_r - CW'(1);
      end
      DP_REM_WR: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_r + CW'(1);
      end
      DP_FINISH: begin
        if (cmd.wr_key) begin
          wr_en   = 1'b1;
          wr_addr = lo_r[AW-1:0];
          wr_data = key_r;
        end
        if (cmd.cnt_inc) begin
          count_nxt = count_r + CW'(1);
        end else if (cmd.cnt_dec) begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt       = cmd.op == DP_FINISH;
    rsp_nxt.status      = cmd.status;
    rsp_nxt.entry_count = cnt_nxt_x[8:0];
    unique case (cmd.pos_src)
      POS_IDX:  rsp_nxt.position = lo_x[7:0];
      POS_SLOT: rsp_nxt.position = slot_r;
      default:  rsp_nxt.position = 8'd0;
    endcase
    rsp_nxt.read_value = cmd.rv_en ? $signed(rd_q) : 32'sd0;
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      key_r  <= req.key;
      slot_r <= req.slot;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    ptr_r   <= ptr_nxt;
    out_rsp <= rsp_nxt;
  end

endmodule

// ----- rtl/core/sse_ctrl.sv -----
// controller: sequences search, probe, shift and finish steps of each request
// depends on sse_pkg
module sse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        kind,
  input  sse_pkg::sse_sts_t sts,
  output logic              busy,
  output sse_pkg::sse_cmd_t cmd
);
  import sse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SRCH,
    S_SRCH_CMP,
    S_PROBE,
    S_INS,
    S_INS_WR,
    S_REM,
    S_REM_WR
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] kind_r;

  assign busy = state_r != S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = DP_NOP;
    cmd.status  = ST_INSERTED;
    cmd.pos_src = POS_NONE;
    cmd.rv_en   = 1'b0;
    cmd.wr_key  = 1'b0;
    cmd.cnt_inc = 1'b0;
    cmd.cnt_dec = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = DP_LOAD;
          state_nxt = (kind == KIND_READ) ? S_RD_WAIT : S_SRCH;
        end
      end
      S_RD_WAIT: begin
        cmd.op    = DP_FINISH;
        state_nxt = S_IDLE;
        if (sts.slot_ok) begin
          cmd.status  = ST_FOUND;
          cmd.pos_src = POS_SLOT;
          cmd.rv_en   = 1'b1;
        end else begin
          cmd.status = ST_READ_RANGE;
        end
      end
      S_SRCH: begin
        if (sts.srch_open) begin
          cmd.op    = DP_SRCH_RD;
          state_nxt = S_SRCH_CMP;
        end else begin
          cmd.op    = DP_PROBE_RD;
          state_nxt = S_PROBE;
        end
      end
      S_SRCH_CMP: begin
        cmd.op    = DP_SRCH_UPD;
        state_nxt = S_SRCH;
      end
      S_PROBE: begin
        priority if (kind_r == KIND_INSERT) begin
          if (sts.hit) begin
            cmd.op      = DP_FINISH;
            cmd.status  = ST_DUPLICATE;
            cmd.pos_src = POS_IDX;
            state_nxt   = S_IDLE;
          end else if (sts.full) begin
            cmd.op     = DP_FINISH;
            cmd.status = ST_FULL;
            state_nxt  = S_IDLE;
          end else begin
            cmd.op    = DP_INIT_INS;
            state_nxt = S_INS;
          end
        end else if (kind_r == KIND_REMOVE) begin
          if (sts.hit) begin
            cmd.op    = DP_INIT_REM;
            state_nxt = S_REM;
          end else begin
            cmd.op     = DP_FINISH;
            cmd.status = ST_NOT_FOUND;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.op    = DP_FINISH;
          state_nxt = S_IDLE;
          if (sts.hit) begin
            cmd.status  = ST_FOUND;
            cmd.pos_src = POS_IDX;
          end else begin
            cmd.status = ST_ABSENT;
          end
        end
      end
      S_INS: begin
        if (sts.ins_more) begin
          cmd.op    = DP_INS_RD;
          state_nxt = S_INS_WR;
        end else begin
          cmd.op      = DP_FINISH;
          cmd.status  = ST_INSERTED;
          cmd.pos_src = POS_IDX;
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_INS_WR: begin
        cmd.op    = DP_INS_WR;
        state_nxt = S_INS;
      end
      S_REM: begin
        if (sts.rem_more) begin
          cmd.op    = DP_REM_RD;
          state_nxt = S_REM_WR;
        end else begin
          cmd.op      = DP_FINISH;
          cmd.status  = ST_REMOVED;
          cmd.pos_src = POS_IDX;
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_REM_WR: begin
        cmd.op    = DP_REM_WR;
        state_nxt = S_REM;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_INSERT;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && start) begin
        kind_r <= kind;
      end
    end
  end

endmodule

// ----- rtl/core/sorted_set_engine.sv -----
// a read goes straight to its result; finds and refused requests run a binary search of k
// halving steps (at most ceil(log2(count+1))) and then a probe; stored inserts and removes
// also shift one entry per read and write step through the one read and one write memory port
// throughput: one request at a time, next start taken the cycle the result strobes
// reset: synchronous active-low rst_n empties the set; entries are not cleared
// top level of the sorted set engine; uses sse_pkg, sse_ctrl and sse_datapath
module sorted_set_engine #(
  parameter int CAPACITY = sse_pkg::DEFAULT_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sse_pkg::sse_req_t in_req,
  output logic              out_valid,
  output sse_pkg::sse_rsp_t out_rsp
);
  import sse_pkg::*;

  sse_cmd_t cmd;
  sse_sts_t sts;

  sse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_req.kind),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  sse_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobed while busy");
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != ST_FOUND |-> out_rsp.read_value == 32'sd0)
    else $error("read value nonzero on non-read result");
`endif

endmodule

// ----- tb/sorted_set_engine_tb.sv -----
// self-checking testbench for sorted_set_engine: directed table, then random requests
// predicts every response with a behavioral sorted set; depends on sse_pkg and the rtl
`timescale 1ns / 1ps

module sorted_set_engine_tb;
  import sse_pkg::*;

  localparam int CAP = 256;
  localparam int N_RANDOM = 1900;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [7:0]  slot;
    bit          fixed;
    sse_rsp_t    rsp;
  } table_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  sse_req_t in_req;
  logic     out_valid;
  sse_rsp_t out_rsp;

  // behavioral copy of the set
  logic signed [31:0] set_vals[$];
  sse_rsp_t           rsp_queue[$];
  int                 mismatches;
  longint             cycle_count;
  table_row_t         rows[$];
  logic signed [31:0] key_pool[$];

  sorted_set_engine #(.CAPACITY(CAP)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic sse_rsp_t set_apply(input sse_req_t r);
    sse_rsp_t res;
    int       idx;
    bit       hit;
    res = '0;
    if (r.kind == KIND_READ) begin
      if (r.slot < set_vals.size()) begin
        res.status = ST_FOUND;
        res.position = r.slot;
        res.read_value = set_vals[r.slot];
      end else begin
        res.status = ST_READ_RANGE;
      end
    end else begin
      idx = 0;
      while (idx < set_vals.size() && set_vals[idx] < r.key) idx++;
      hit = (idx < set_vals.size()) && (set_vals[idx] == r.key);
      case (r.kind)
        KIND_INSERT: begin
          if (hit) begin
            res.status = ST_DUPLICATE; res.position = idx[7:0];
          end else if (set_vals.size() >= CAP) begin
            res.status = ST_FULL;
          end else begin
            set_vals.insert(idx, r.key);
            res.status = ST_INSERTED; res.position = idx[7:0];
          end
        end
        KIND_REMOVE: begin
          if (hit) begin
            set_vals.delete(idx);
            res.status = ST_REMOVED; res.position = idx[7:0];
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
        default: begin
          if (hit) begin
            res.status = ST_FOUND; res.position = idx[7:0];
          end else begin
            res.status = ST_ABSENT;
          end
        end
      endcase
    end
    res.entry_count = 9'(set_vals.size());
    return res;
  endfunction

  task automatic send_req(input logic [1:0] kind, input logic [31:0] key,
                          input logic [7:0] slot, input bit fixed, input sse_rsp_t typed);
    sse_req_t r;
    sse_rsp_t pred;
    int       gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.kind = kind; r.key = key; r.slot = slot;
    start <= 1'b1;
    in_req <= r;
    // busy is stable at the falling edge; low there means the next rising edge accepts
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pred = set_apply(r);
    if (fixed && pred != typed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: table %h predictor %h", typed, pred);
    end
    rsp_queue = {rsp_queue, pred};
  endtask

  // response checker
  always @(posedge clk) begin
    sse_rsp_t exp_rsp;
    if (rst_n && out_valid) begin
      if (rsp_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %h", out_rsp);
      end else begin
        exp_rsp = rsp_queue.pop_front();
        if (out_rsp.status !== exp_rsp.status || out_rsp.position !== exp_rsp.position ||
            out_rsp.entry_count !== exp_rsp.entry_count ||
            out_rsp.read_value !== exp_rsp.read_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d pos=%0d cnt=%0d rv=%h act st=%0d pos=%0d cnt=%0d rv=%h",
                     exp_rsp.status, exp_rsp.position, exp_rsp.entry_count,
                     exp_rsp.read_value, out_rsp.status, out_rsp.position,
                     out_rsp.entry_count, out_rsp.read_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic sse_rsp_t mk(input logic [2:0] st, input logic [7:0] pos,
                                  input logic [8:0] cnt, input logic [31:0] rv);
    sse_rsp_t r;
    r.status = st; r.position = pos; r.entry_count = cnt; r.read_value = rv;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] kind, input logic [31:0] key,
                         input logic [7:0] slot, input bit fixed, input sse_rsp_t rsp);
    table_row_t t;
    t.kind = kind; t.key = key; t.slot = slot; t.fixed = fixed; t.rsp = rsp;
    rows = {rows, t};
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (sel < 8) return $urandom;
    return (sel == 8) ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  initial begin
    int       phase_len;
    bit       grow;
    logic [1:0] kind;
    logic [7:0] slot;
    mismatches = 0;
    cycle_count = 0;
    start = 1'b0;
    in_req = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extremes, duplicates, missing values, out of range reads
    add_row(KIND_READ,   32'h0,         8'd0,   1, mk(ST_READ_RANGE, 0, 0, 0));
    add_row(KIND_FIND,   32'h0,         8'd0,   1, mk(ST_ABSENT, 0, 0, 0));
    add_row(KIND_REMOVE, 32'h5,         8'd0,   1, mk(ST_NOT_FOUND, 0, 0, 0));
    add_row(KIND_INSERT, 32'h7fffffff,  8'd0,   1, mk(ST_INSERTED, 0, 1, 0));
    add_row(KIND_INSERT, 32'h80000000,  8'd0,   1, mk(ST_INSERTED, 0, 2, 0));
    add_row(KIND_INSERT, 32'hffffffff,  8'd0,   1, mk(ST_INSERTED, 1, 3, 0));
    add_row(KIND_INSERT, 32'h0,         8'd0,   1, mk(ST_INSERTED, 2, 4, 0));
    add_row(KIND_INSERT, 32'h80000000,  8'd0,   1, mk(ST_DUPLICATE, 0, 4, 0));
    add_row(KIND_READ,   32'h0,         8'd0,   1, mk(ST_FOUND, 0, 4, 32'h80000000));
    add_row(KIND_READ,   32'hffffffff,  8'd3,   1, mk(ST_FOUND, 3, 4, 32'h7fffffff));
    add_row(KIND_READ,   32'h0,         8'd4,   1, mk(ST_READ_RANGE, 0, 4, 0));
    add_row(KIND_READ,   32'h0,         8'd255, 1, mk(ST_READ_RANGE, 0, 4, 0));
    add_row(KIND_FIND,   32'hffffffff,  8'd0,   1, mk(ST_FOUND, 1, 4, 0));
    add_row(KIND_FIND,   32'h1,         8'd0,   1, mk(ST_ABSENT, 0, 4, 0));
    add_row(KIND_REMOVE, 32'h80000000,  8'd0,   1, mk(ST_REMOVED, 0, 3, 0));
    add_row(KIND_REMOVE, 32'h80000000,  8'd0,   1, mk(ST_NOT_FOUND, 0, 3, 0));
    add_row(KIND_INSERT, 32'h5a5a5a5a,  8'd0,   0, '0);
    add_row(KIND_REMOVE, 32'h7fffffff,  8'd0,   0, '0);
    add_row(KIND_READ,   32'h0,         8'd2,   0, '0);
    foreach (rows[i]) send_req(rows[i].kind, rows[i].key, rows[i].slot, rows[i].fixed, rows[i].rsp);

    // random phases alternate filling toward full and draining toward empty
    grow = 1;
    for (int n = 0; n < N_RANDOM; ) begin
      phase_len = $urandom_range(40, 400);
      for (int j = 0; j < phase_len && n < N_RANDOM; j++, n++) begin
        // full store reached occasionally: fill fast through the insert-heavy mix
        if (grow) kind = ($urandom_range(0, 9) < 7) ? KIND_INSERT : 2'($urandom_range(1, 3));
        else      kind = ($urandom_range(0, 9) < 6) ? KIND_REMOVE : 2'($urandom_range(0, 3));
        slot = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
               8'($urandom_range(0, set_vals.size() > 0 ? set_vals.size() - 1 : 0));
        if (kind == KIND_REMOVE || kind == KIND_FIND) begin
          if (set_vals.size() > 0 && $urandom_range(0, 3) != 0)
            send_req(kind, set_vals[$urandom_range(0, set_vals.size() - 1)], slot, 0, '0);
          else
            send_req(kind, pick_key(), slot, 0, '0);
        end else begin
          send_req(kind, (kind == KIND_INSERT && $urandom_range(0, 4) != 0) ?
                   32'($urandom) : pick_key(), slot, 0, '0);
          if (kind == KIND_INSERT) key_pool = {key_pool, in_req.key};
        end
      end
      grow = !grow;
    end
    start <= 1'b0;

    while (rsp_queue.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sse_pkg.sv
rtl/core/sse_datapath.sv
rtl/core/sse_ctrl.sv
rtl/core/sorted_set_engine.sv
tb/sorted_set_engine_tb.sv
